// ===== design/shms_pkg.sv =====
// Shared types and constants for the strip hit multiplicity selector.
// Used by the threshold table, the accumulator stage and the top level.
`timescale 1ns / 1ps

package shms_pkg;

  // Default parameter values
  localparam int unsigned STRIPS_PER_SIDE_DEF = 128;
  localparam int unsigned ADC_BITS_DEF        = 10;

  // Fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CH_W     = 7;
  localparam int unsigned TAB_AW   = 8;
  localparam int unsigned TAB_DEPTH = 256;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned SEL_W    = 8;
  localparam int unsigned ENERGY_W = 17;
  localparam int unsigned CHSUM_W  = 14;

  // Item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_END    = 2'd2
  } shms_op_e;

  // Control for one item entering the accumulate stage
  typedef struct packed {
    logic sample;  // strip sample: compare and accumulate
    logic finish;  // side ends with this item
    logic side;    // side named by this item
  } shms_step_t;

  // One side summary
  typedef struct packed {
    logic                result_side;
    logic [CNT_W-1:0]    hit_count;
    logic [CLASS_W-1:0]  hit_class;
    logic                interior;
    logic [SEL_W-1:0]    selected_channel;
    logic [ENERGY_W-1:0] energy_sum;
    logic [CHSUM_W-1:0]  channel_sum;
    logic                keep_event;
  } shms_result_t;

endpackage

// ===== design/shms_thr_table.sv =====
// Per-channel threshold memory: one write port, one registered read port.
// Valid bits make unwritten entries read as zero after reset. Uses shms_pkg.
`timescale 1ns / 1ps

module shms_thr_table #(
  parameter int unsigned ADC_BITS = shms_pkg::ADC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [shms_pkg::TAB_AW-1:0] wr_addr_i,
  input  logic [ADC_BITS-1:0]         wr_data_i,
  input  logic                        rd_en_i,
  input  logic [shms_pkg::TAB_AW-1:0] rd_addr_i,
  output logic [ADC_BITS-1:0]         rd_data_o
);
  import shms_pkg::*;

  logic [ADC_BITS-1:0]  mem [TAB_DEPTH];
  logic [TAB_DEPTH-1:0] vld_q;
  logic [ADC_BITS-1:0]  rd_data_q;
  logic                 rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Entry valid bits and registered read valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Never-written entries read as their reset value of zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/shms_accum.sv =====
// Hit compare and per-side accumulation, with side summary formation.
// Holds counters, sums, last-hit info and held selections. Uses shms_pkg.
`timescale 1ns / 1ps

module shms_accum #(
  parameter int unsigned STRIPS_PER_SIDE = shms_pkg::STRIPS_PER_SIDE_DEF,
  parameter int unsigned ADC_BITS        = shms_pkg::ADC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  shms_pkg::shms_step_t      step_i,
  input  logic [shms_pkg::CH_W-1:0] channel_i,
  input  logic [ADC_BITS-1:0]       adc_i,
  input  logic [ADC_BITS-1:0]       thr_i,
  output shms_pkg::shms_result_t    result_o
);
  import shms_pkg::*;

  localparam int unsigned POS_W = $clog2(STRIPS_PER_SIDE);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(STRIPS_PER_SIDE - 1);

  logic [CNT_W-1:0]    cnt_q, cnt_upd;
  logic [ENERGY_W-1:0] energy_q, energy_upd;
  logic [CHSUM_W-1:0]  chsum_q, chsum_upd;
  logic [POS_W-1:0]    pos_q, pos_upd;
  logic [POS_W-1:0]    lhp_q, lhp_upd;
  logic [CH_W-1:0]     lhc_q, lhc_upd;
  logic [SEL_W-1:0]    held_front_q, held_back_q;
  logic                fws_q;
  logic                hit;
  logic [ENERGY_W:0]   energy_add;
  logic [CHSUM_W:0]    chsum_add;
  logic [CLASS_W-1:0]  cls;
  logic                single;
  logic [SEL_W-1:0]    sel_new;
  logic [SEL_W-1:0]    sel;

  // Strict compare against the channel threshold
  assign hit = step_i.sample && (adc_i > thr_i);

  // Saturating updates; the sum ceilings are all-ones, so carry-out saturates
  assign energy_add = {1'b0, energy_q} + (ENERGY_W + 1)'(adc_i);
  assign chsum_add  = {1'b0, chsum_q} + (CHSUM_W + 1)'(channel_i);

  always_comb begin
    cnt_upd    = cnt_q;
    energy_upd = energy_q;
    chsum_upd  = chsum_q;
    lhp_upd    = lhp_q;
    lhc_upd    = lhc_q;
    pos_upd    = pos_q;
    if (hit) begin
      if (cnt_q != '1) begin
        cnt_upd = cnt_q + 1'b1;
      end
      energy_upd = energy_add[ENERGY_W] ? '1 : energy_add[ENERGY_W-1:0];
      chsum_upd  = chsum_add[CHSUM_W] ? '1 : chsum_add[CHSUM_W-1:0];
      lhp_upd    = pos_q;
      lhc_upd    = channel_i;
    end
    if (step_i.sample && (pos_q != POS_MAX)) begin
      pos_upd = pos_q + 1'b1;
    end
  end

  // Side summary from the values after this item
  assign cls     = (cnt_upd >= CNT_W'(1) && cnt_upd <= CNT_W'(3)) ? cnt_upd[CLASS_W-1:0] : '0;
  assign single  = (cnt_upd == CNT_W'(1));
  assign sel_new = {step_i.side, lhc_upd};

  always_comb begin
    if (cls != '0) begin
      sel = sel_new;
    end else begin
      sel = step_i.side ? held_back_q : held_front_q;
    end
  end

  always_comb begin
    result_o.result_side      = step_i.side;
    result_o.hit_count        = cnt_upd;
    result_o.hit_class        = cls;
    result_o.interior         = (cnt_upd != '0) && (lhp_upd != '0) && (lhp_upd != POS_MAX);
    result_o.selected_channel = sel;
    result_o.energy_sum       = energy_upd;
    result_o.channel_sum      = chsum_upd;
    result_o.keep_event       = step_i.side && (fws_q || single);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      energy_q     <= '0;
      chsum_q      <= '0;
      pos_q        <= '0;
      lhp_q        <= '0;
      lhc_q        <= '0;
      held_front_q <= '0;
      held_back_q  <= '0;
      fws_q        <= 1'b0;
    end else if (adv_i) begin
      lhp_q <= lhp_upd;
      lhc_q <= lhc_upd;
      if (step_i.finish) begin
        cnt_q    <= '0;
        energy_q <= '0;
        chsum_q  <= '0;
        pos_q    <= '0;
        if (cls != '0) begin
          if (step_i.side) begin
            held_back_q <= sel_new;
          end else begin
            held_front_q <= sel_new;
          end
        end
        fws_q <= step_i.side ? 1'b0 : single;
      end else begin
        cnt_q    <= cnt_upd;
        energy_q <= energy_upd;
        chsum_q  <= chsum_upd;
        pos_q    <= pos_upd;
      end
    end
  end

endmodule

// ===== design/strip_hit_multiplicity_selector_core.sv =====
// Strip hit multiplicity selector, top level: input register, threshold
// table, accumulate stage and result register. Uses shms_pkg, shms_thr_table
// and shms_accum.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one item: a threshold
//    load (op 0), a strip sample (op 1) or an end-of-side marker (op 2).
//    Pseudo items and op 3 are accepted and dropped.
//  - Output channel (out_valid_o / out_stall_i) carries one side summary at
//    the strip marked last or at an end marker.
//  - The table is read when the ending item is accepted into the input register;
//    compare and sums follow, and the summary is captured in the result register.
//  - Throughput: one item per cycle while in_stall_o is low; the table has one write
//    and one read port and the accumulate stage takes one item each cycle it advances.
//  - When the receiver stalls, the summary waits in the output register;
//    items that end no side keep flowing, and input stalls only once an
//    ending item reaches the accumulate stage behind a waiting summary.
//  - Reset clears all sums, counters, held selections and the table's
//    entry valid bits, so every threshold reads as zero until loaded. No
//    clearing pass: items are taken right after reset.
`timescale 1ns / 1ps

module strip_hit_multiplicity_selector_core #(
  parameter int unsigned STRIPS_PER_SIDE = shms_pkg::STRIPS_PER_SIDE_DEF,
  parameter int unsigned ADC_BITS        = shms_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [shms_pkg::OP_W-1:0]     op_i,
  input  logic                          pseudo_i,
  input  logic                          side_i,
  input  logic [shms_pkg::CH_W-1:0]     channel_i,
  input  logic [ADC_BITS-1:0]           adc_value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_side_o,
  output logic [shms_pkg::CNT_W-1:0]    hit_count_o,
  output logic [shms_pkg::CLASS_W-1:0]  hit_class_o,
  output logic                          interior_o,
  output logic [shms_pkg::SEL_W-1:0]    selected_channel_o,
  output logic [shms_pkg::ENERGY_W-1:0] energy_sum_o,
  output logic [shms_pkg::CHSUM_W-1:0]  channel_sum_o,
  output logic                          keep_event_o
);
  import shms_pkg::*;

  logic                accept;
  logic                useful;
  logic                tbl_we;
  logic [TAB_AW-1:0]   tbl_addr;
  logic [ADC_BITS-1:0] thr;

  logic                s1_valid_q;
  shms_step_t          s1_step_q, step_d;
  logic [CH_W-1:0]     s1_ch_q;
  logic [ADC_BITS-1:0] s1_adc_q;
  logic                s1_go;
  logic                adv;

  shms_result_t        res;
  shms_result_t        out_q;
  logic                out_valid_q;

  // Input decode
  assign accept   = in_valid_i && !in_stall_o;
  assign useful   = !pseudo_i && ((op_i == OP_SAMPLE) || (op_i == OP_END));
  assign tbl_we   = accept && !pseudo_i && (op_i == OP_LOAD);
  assign tbl_addr = {side_i, channel_i};

  always_comb begin
    step_d.sample = (op_i == OP_SAMPLE);
    step_d.finish = (op_i == OP_END) || ((op_i == OP_SAMPLE) && last_i);
    step_d.side   = side_i;
  end

  // The accumulate stage moves unless its summary has nowhere to go
  assign s1_go      = !s1_valid_q || !s1_step_q.finish || !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && s1_go;
  assign in_stall_o = !s1_go;

  // Threshold table; read data lines up with the input register
  shms_thr_table #(
    .ADC_BITS (ADC_BITS)
  ) u_thr_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_addr),
    .wr_data_i (adc_value_i),
    .rd_en_i   (accept),
    .rd_addr_i (tbl_addr),
    .rd_data_o (thr)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_go) begin
      s1_valid_q <= in_valid_i && useful;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_step_q <= step_d;
      s1_ch_q   <= channel_i;
      s1_adc_q  <= adc_value_i;
    end
  end

  // Compare and accumulate
  shms_accum #(
    .STRIPS_PER_SIDE (STRIPS_PER_SIDE),
    .ADC_BITS        (ADC_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .step_i    (s1_step_q),
    .channel_i (s1_ch_q),
    .adc_i     (s1_adc_q),
    .thr_i     (thr),
    .result_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_step_q.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_step_q.finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_side_o      = out_q.result_side;
  assign hit_count_o        = out_q.hit_count;
  assign hit_class_o        = out_q.hit_class;
  assign interior_o         = out_q.interior;
  assign selected_channel_o = out_q.selected_channel;
  assign energy_sum_o       = out_q.energy_sum;
  assign channel_sum_o      = out_q.channel_sum;
  assign keep_event_o       = out_q.keep_event;

  // Checks
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty accumulate stage");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && s1_step_q.finish))
    else $error("summary appeared without an ending item");

  a_class_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.hit_class != '0)) |->
      (out_q.hit_count == CNT_W'(out_q.hit_class)))
    else $error("hit class disagrees with hit count");

  a_interior_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.interior) |-> (out_q.hit_count != '0))
    else $error("interior flag set with no hits");

  a_keep_only_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.keep_event) |-> out_q.result_side)
    else $error("keep flag on a front summary");

endmodule
